### src/ntc_table_search_interpolate_defines.svh
// ----------------------------------------------------------------------------
// ntc_table_search_interpolate_defines
// Assertion macros shared by the thermistor lookup checker.
// ----------------------------------------------------------------------------
`ifndef NTC_TABLE_SEARCH_INTERPOLATE_DEFINES_SVH
`define NTC_TABLE_SEARCH_INTERPOLATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ntc_tsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_tsi_pkg
// Shared widths, codes and types of the thermistor table lookup block.
// ----------------------------------------------------------------------------
package ntc_tsi_pkg;

	localparam int ADC_W         = 10;
	localparam int ENTRY_IDX_W   = 8;
	localparam int TEMP_W        = 17;
	localparam int STATUS_W      = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 9;
	localparam int CFG_ENTRIES_W = 9;
	localparam int CFG_OFFSET_W  = 8;

	localparam logic [CFG_ENTRIES_W-1:0] ENTRIES_RST = 9'd201;
	localparam logic [CFG_OFFSET_W-1:0]  OFFSET_RST  = 8'd72;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CONV = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 1'b1;

	localparam logic [STATUS_W-1:0] RS_IN_RANGE = 2'd0;
	localparam logic [STATUS_W-1:0] RS_BELOW    = 2'd1;
	localparam logic [STATUS_W-1:0] RS_ABOVE    = 2'd2;

	typedef struct packed {
		logic                done;
		logic [STATUS_W-1:0] status;
		logic                zero;
		logic                frac;
	} srch_res_t;

endpackage

### src/ntc_table_search_interpolate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_search_interpolate
// Thermistor ADC sample to Q-format temperature via a loadable table,
// binary search and linear interpolation.
// ----------------------------------------------------------------------------
// A load item (req_type 0) writes one table entry and leaves the block free;
// loads beyond TABLE_DEPTH are dropped. A convert item (req_type 1) is
// searched one item at a time: each search probe reads the middle entry
// through the table memory's read port, then the upper or lower neighbour
// (and entry 0 on a downward miss), and a search takes about
// ceil(log2(entries_in_use)) + 1 probes. An in-range hit that falls between
// entries then runs a restoring divider for FRAC_BITS + 1 quotient bits,
// with its start and done strobes registered. The next item can be taken
// in the cycle after the result leaves the search. The result sits in an
// output register, so the next item is taken while it waits. Table entries
// have no reset: every entry a conversion may touch must be loaded first.
// The table must ascend with index.
// ----------------------------------------------------------------------------
module ntc_table_search_interpolate #(
	parameter int TABLE_DEPTH = 256,
	parameter int ADC_BITS    = 10,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic [ntc_tsi_pkg::ENTRY_IDX_W-1:0]    entry_index,
	input  logic [ntc_tsi_pkg::ADC_W-1:0]          entry_value,
	input  logic [ntc_tsi_pkg::ADC_W-1:0]          adc_sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [ntc_tsi_pkg::TEMP_W-1:0]  temperature_q8,
	output logic [ntc_tsi_pkg::STATUS_W-1:0]       range_status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ntc_tsi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntc_tsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import ntc_tsi_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CW0   = $clog2(TABLE_DEPTH + 1);
	localparam int CW    = (CW0 > CFG_ENTRIES_W) ? CW0 : CFG_ENTRIES_W;
	localparam int BW    = (IDX_W > CFG_OFFSET_W) ? IDX_W : CFG_OFFSET_W;
	localparam int SW0   = BW + FRAC_BITS + 3;
	localparam int SW    = (SW0 > TEMP_W + 1) ? SW0 : TEMP_W + 1;
	localparam logic signed [SW-1:0] T_MIN = SW'(-65536);
	localparam logic signed [SW-1:0] T_MAX = SW'(65535);

	logic [CFG_ENTRIES_W-1:0] entries_q;
	logic [CFG_OFFSET_W-1:0]  offset_q;
	logic [CW-1:0]            n_ext;
	logic [CW-1:0]            n_cl;
	logic [IDX_W-1:0]         last_idx;

	logic                     in_acc;
	logic                     conv_start;
	logic                     tbl_we;
	logic [ADC_W+ADC_BITS-1:0] sample_ext;
	logic [ADC_W+ADC_BITS-1:0] value_ext;
	logic [ADC_BITS-1:0]      sample_w;
	logic [ADC_BITS-1:0]      value_w;

	logic [IDX_W-1:0]         rd_addr;
	logic [ADC_BITS-1:0]      rd_data;
	logic                     div_start;
	logic [ADC_BITS-1:0]      div_diff;
	logic [ADC_BITS-1:0]      div_den;
	logic                     div_done;
	logic [FRAC_BITS:0]       div_quot;
	srch_res_t                res;
	logic [IDX_W-1:0]         base_idx;
	logic                     busy;
	logic                     res_ready;

	logic signed [SW-1:0]     whole_v;
	logic signed [SW-1:0]     sum_v;
	logic signed [SW-1:0]     sat_v;

	logic                     out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [STATUS_W-1:0]      status_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RST;
			offset_q  <= OFFSET_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ENTRIES: entries_q <= cfg_data;
				CFG_OFFSET:  offset_q  <= cfg_data[CFG_OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign n_ext    = CW'(entries_q);
	assign n_cl     = (n_ext < CW'(2)) ? CW'(2) :
	                  ((n_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : n_ext);
	assign last_idx = IDX_W'(n_cl - CW'(1));

	// input side
	assign in_stall   = busy;
	assign in_acc     = in_valid && !in_stall;
	assign conv_start = in_acc && (req_type == REQ_CONV);
	assign tbl_we     = in_acc && (req_type == REQ_LOAD) &&
	                    (CW'(entry_index) < CW'(TABLE_DEPTH));
	assign sample_ext = {{ADC_BITS{1'b0}}, adc_sample};
	assign value_ext  = {{ADC_BITS{1'b0}}, entry_value};
	assign sample_w   = sample_ext[ADC_BITS-1:0];
	assign value_w    = value_ext[ADC_BITS-1:0];

	ntc_tsi_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ADC_BITS)
	) u_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (IDX_W'(entry_index)),
		.wdata (value_w),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ntc_tsi_search #(
		.IDX_W    (IDX_W),
		.ADC_BITS (ADC_BITS)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (conv_start),
		.sample    (sample_w),
		.last_idx  (last_idx),
		.res_ready (res_ready),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.div_start (div_start),
		.div_diff  (div_diff),
		.div_den   (div_den),
		.div_done  (div_done),
		.res       (res),
		.base_idx  (base_idx),
		.busy      (busy)
	);

	ntc_tsi_div #(
		.ADC_BITS  (ADC_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (div_diff),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// (base - offset) * 2^FRAC + fraction, saturated; zero for a below-range result
	always_comb begin
		whole_v = $signed(SW'(base_idx)) - $signed(SW'(offset_q));
		sum_v   = (whole_v <<< FRAC_BITS) + (res.frac ? $signed(SW'(div_quot)) : '0);
		if (res.zero) begin
			sat_v = '0;
		end else if (sum_v < T_MIN) begin
			sat_v = T_MIN;
		end else if (sum_v > T_MAX) begin
			sat_v = T_MAX;
		end else begin
			sat_v = sum_v;
		end
	end

	// output register
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			temp_q   <= sat_v[TEMP_W-1:0];
			status_q <= res.status;
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature_q8 = temp_q;
	assign range_status   = status_q;

endmodule

### src/ntc_tsi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_tsi_ram
// Calibration table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ntc_tsi_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/ntc_tsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_tsi_div
// Restoring divider for the segment fraction, one quotient bit per cycle.
// Dividend is diff * 2^FRAC_BITS with diff <= den.
// ----------------------------------------------------------------------------
module ntc_tsi_div #(
	parameter int ADC_BITS  = 10,
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADC_BITS-1:0]  diff,
	input  logic [ADC_BITS-1:0]  den,
	output logic                 done,
	output logic [FRAC_BITS:0]   quot
);

	localparam int QW    = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(FRAC_BITS + 2);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADC_BITS:0]   rem_q;
	logic [ADC_BITS-1:0] den_q;
	logic [QW-1:0]       quot_q;
	logic                ge;
	logic [ADC_BITS:0]   rsub;

	assign ge   = rem_q >= {1'b0, den_q};
	assign rsub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, diff};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rsub << 1;
			quot_q <= (quot_q << 1) | QW'(ge);
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### src/ntc_tsi_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_tsi_search
// Binary search sequencer over the table memory; finds the bracketing
// segment and hands the fraction to the divider.
// ----------------------------------------------------------------------------
module ntc_tsi_search #(
	parameter int IDX_W    = 8,
	parameter int ADC_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [ADC_BITS-1:0]    sample,
	input  logic [IDX_W-1:0]       last_idx,
	input  logic                   res_ready,
	output logic [IDX_W-1:0]       rd_addr,
	input  logic [ADC_BITS-1:0]    rd_data,
	output logic                   div_start,
	output logic [ADC_BITS-1:0]    div_diff,
	output logic [ADC_BITS-1:0]    div_den,
	input  logic                   div_done,
	output ntc_tsi_pkg::srch_res_t res,
	output logic [IDX_W-1:0]       base_idx,
	output logic                   busy
);

	import ntc_tsi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PM,
		S_PUP,
		S_PDN,
		S_PT0,
		S_DIV,
		S_FIN
	} state_t;

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     left_q, left_d;
	logic [IDX_W-1:0]     right_q, right_d;
	logic [IDX_W-1:0]     m_q, m_d;
	logic [ADC_BITS-1:0]  sample_q, sample_d;
	logic [ADC_BITS-1:0]  tm_q, tm_d;
	logic [IDX_W-1:0]     base_q, base_d;
	logic [STATUS_W-1:0]  status_q, status_d;
	logic                 zero_q, zero_d;
	logic                 frac_q, frac_d;
	logic                 dstart_q, dstart_d;
	logic [ADC_BITS-1:0]  diff_q, diff_d;
	logic [ADC_BITS-1:0]  den_q, den_d;

	logic                 gt;
	logic                 lt;
	logic [IDX_W-1:0]     nm_up;
	logic [IDX_W-1:0]     nm_dn;

	assign gt    = sample_q > rd_data;
	assign lt    = sample_q < rd_data;
	assign nm_up = m_q + ((right_q - m_q) >> 1);
	assign nm_dn = left_q + ((m_q - left_q) >> 1);

	always_comb begin
		state_d  = state_q;
		left_d   = left_q;
		right_d  = right_q;
		m_d      = m_q;
		sample_d = sample_q;
		tm_d     = tm_q;
		base_d   = base_q;
		status_d = status_q;
		zero_d   = zero_q;
		frac_d   = frac_q;
		dstart_d = 1'b0;
		diff_d   = diff_q;
		den_d    = den_q;
		rd_addr  = m_q;
		case (state_q)
			S_IDLE: begin
				rd_addr = last_idx >> 1;
				if (start) begin
					sample_d = sample;
					left_d   = '0;
					right_d  = last_idx;
					m_d      = last_idx >> 1;
					state_d  = S_PM;
				end
			end
			S_PM: begin
				tm_d = rd_data;
				if (!gt && !lt) begin
					base_d   = m_q;
					status_d = RS_IN_RANGE;
					zero_d   = 1'b0;
					frac_d   = 1'b0;
					state_d  = S_FIN;
				end else if (gt) begin
					if (m_q != last_idx) begin
						rd_addr = m_q + IDX_W'(1);
						state_d = S_PUP;
					end else if (m_q == left_q) begin
						base_d   = last_idx;
						status_d = RS_ABOVE;
						zero_d   = 1'b0;
						frac_d   = 1'b0;
						state_d  = S_FIN;
					end else begin
						left_d  = m_q;
						m_d     = nm_up;
						rd_addr = nm_up;
					end
				end else if (m_q != '0) begin
					rd_addr = m_q - IDX_W'(1);
					state_d = S_PDN;
				end else begin
					status_d = RS_BELOW;
					zero_d   = 1'b1;
					frac_d   = 1'b0;
					state_d  = S_FIN;
				end
			end
			S_PUP: begin
				if (!gt) begin
					base_d   = m_q;
					diff_d   = sample_q - tm_q;
					den_d    = rd_data - tm_q;
					dstart_d = 1'b1;
					status_d = RS_IN_RANGE;
					zero_d   = 1'b0;
					frac_d   = 1'b1;
					state_d  = S_DIV;
				end else if (m_q == left_q) begin
					base_d   = last_idx;
					status_d = RS_ABOVE;
					zero_d   = 1'b0;
					frac_d   = 1'b0;
					state_d  = S_FIN;
				end else begin
					left_d  = m_q;
					m_d     = nm_up;
					rd_addr = nm_up;
					state_d = S_PM;
				end
			end
			S_PDN: begin
				if (!lt) begin
					base_d   = m_q - IDX_W'(1);
					diff_d   = sample_q - rd_data;
					den_d    = tm_q - rd_data;
					dstart_d = 1'b1;
					status_d = RS_IN_RANGE;
					zero_d   = 1'b0;
					frac_d   = 1'b1;
					state_d  = S_DIV;
				end else begin
					rd_addr = '0;
					state_d = S_PT0;
				end
			end
			S_PT0: begin
				if (lt || (m_q == right_q)) begin
					status_d = RS_BELOW;
					zero_d   = 1'b1;
					frac_d   = 1'b0;
					state_d  = S_FIN;
				end else begin
					right_d = m_q;
					m_d     = nm_dn;
					rd_addr = nm_dn;
					state_d = S_PM;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			dstart_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			dstart_q <= dstart_d;
		end
	end

	always_ff @(posedge clk) begin
		left_q   <= left_d;
		right_q  <= right_d;
		m_q      <= m_d;
		sample_q <= sample_d;
		tm_q     <= tm_d;
		base_q   <= base_d;
		status_q <= status_d;
		zero_q   <= zero_d;
		frac_q   <= frac_d;
		diff_q   <= diff_d;
		den_q    <= den_d;
	end

	assign div_start  = dstart_q;
	assign div_diff   = diff_q;
	assign div_den    = den_q;
	assign res.done   = (state_q == S_FIN) && res_ready;
	assign res.status = status_q;
	assign res.zero   = zero_q;
	assign res.frac   = frac_q;
	assign base_idx   = base_q;
	assign busy       = state_q != S_IDLE;

endmodule

### src/ntc_tsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_tsi_checker
// Port-level assertions for the thermistor table lookup, bound to the top.
// ----------------------------------------------------------------------------
`include "ntc_table_search_interpolate_defines.svh"

module ntc_tsi_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  req_type,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [ntc_tsi_pkg::TEMP_W-1:0] temperature_q8,
	input logic [ntc_tsi_pkg::STATUS_W-1:0]      range_status
);

	import ntc_tsi_pkg::*;

	`TSI_ASSERT_NEXT(a_conv_busy, in_valid && !in_stall && (req_type == REQ_CONV), in_stall, "conversion item not held off")

	`TSI_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (req_type == REQ_LOAD), !in_stall, "load item left block busy")

	`TSI_ASSERT_SAME(a_below_zero, out_valid && (range_status == RS_BELOW), temperature_q8 == '0, "below-range item with non-zero temperature")

	`TSI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(temperature_q8) && $stable(range_status), "stalled result item changed")

endmodule

bind ntc_table_search_interpolate ntc_tsi_checker u_chk (.*);
